// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the ramp controller RTL.
// Each macro wraps a clocked property that is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that cond implies prop at the next rising edge of clk_i.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/dacramp_pkg.sv -----
// Shared types and constants for the two-channel DAC soft-start ramp.
// Used by the decoder, the command queue, the executor and the top level.
package dacramp_pkg;

  // Input function codes.
  typedef enum logic [3:0] {
    FUNC_RAMP_TICK = 4'd0,
    FUNC_SLOW_TICK = 4'd1,
    FUNC_START     = 4'd2,
    FUNC_STOP      = 4'd3,
    FUNC_JOG1_UP   = 4'd4,
    FUNC_JOG1_DN   = 4'd5,
    FUNC_JOG2_UP   = 4'd6,
    FUNC_JOG2_DN   = 4'd7,
    FUNC_LOAD1     = 4'd8,
    FUNC_LOAD2     = 4'd9
  } func_e;

  // Decoded operations, coil gating already applied.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RAMP,
    OP_SLOW,
    OP_START,
    OP_STOP,
    OP_JOG1_UP,
    OP_JOG1_DN,
    OP_JOG2_UP,
    OP_JOG2_DN,
    OP_LOAD1,
    OP_LOAD2
  } op_e;

  localparam int unsigned FUNC_W  = 4;
  localparam int unsigned LOAD_W  = 12;
  localparam int unsigned OUT_W   = 13;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned JOG_W   = 12;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_STEP = 2'd0,
    CFG_JOG_MAX   = 2'd1,
    CFG_JOG_MIN   = 2'd2,
    CFG_OFF_DELAY = 2'd3
  } cfg_idx_e;

  localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 8'd10;
  localparam logic [JOG_W-1:0]   JOG_MAX_RST   = 12'd4095;
  localparam logic [JOG_W-1:0]   JOG_MIN_RST   = 12'd100;
  localparam logic [DELAY_W-1:0] OFF_DELAY_RST = 8'd20;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    op_e               op;
    logic [LOAD_W-1:0] value;
  } cmd_t;

endpackage

// ----- rtl/two_channel_dac_soft_start_ramp.sv -----
// Top level of the two-channel DAC soft-start ramp controller.
// Depends on dacramp_pkg, dacramp_front, dacramp_queue and dacramp_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per item:
//   func_i selects ramp tick, slow tick, start, stop, setpoint jog or load;
//   coil_on_i gates start, stop and jog; load_value_i feeds the loads.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   item per input item: both drive values, the DAC update strobe, the
//   relay level and the auto-mode flag after that event.
//   Items are decoded into a two-entry command queue; the executor pops one
//   command per cycle into a registered result slot unless a stalled result
//   still holds it. Each item passes through a queue entry and then the
//   result slot before out_valid_o rises; sustained throughput is one item
//   per cycle while the receiver does not stall.
//   When the receiver stalls, the result slot holds, the queue fills, and
//   in_stall_o rises once both queue entries are taken.
//   Reset clears drives, setpoints, pending flags, relay and delay count,
//   and loads the register defaults: step 10, jog limits 4095 and 100,
//   off delay 20. Write configuration through cfg_we_i only while idle.
module two_channel_dac_soft_start_ramp #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dacramp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dacramp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dacramp_pkg::FUNC_W-1:0]    func_i,
  input  logic                              coil_on_i,
  input  logic [dacramp_pkg::LOAD_W-1:0]    load_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dacramp_pkg::OUT_W-1:0]     dac_one_o,
  output logic [dacramp_pkg::OUT_W-1:0]     dac_two_o,
  output logic                              dac_update_o,
  output logic                              relay_on_o,
  output logic                              auto_active_o
);
  import dacramp_pkg::*;

  cmd_t dec_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  dacramp_front u_front (
    .func_i       (func_i),
    .coil_on_i    (coil_on_i),
    .load_value_i (load_value_i),
    .cmd_o        (dec_cmd)
  );

  dacramp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (dec_cmd),
    .pop_i      (q_pop),
    .head_cmd_o (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  dacramp_back #(
    .DAC_BITS (DAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_avail_i   (!q_empty),
    .cmd_i         (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dac_one_o     (dac_one_o),
    .dac_two_o     (dac_two_o),
    .dac_update_o  (dac_update_o),
    .relay_on_o    (relay_on_o),
    .auto_active_o (auto_active_o)
  );

endmodule

// ----- rtl/dacramp_front.sv -----
// Front end: classifies one input item into a queued command.
// Depends on dacramp_pkg for the function codes and the command type.
module dacramp_front (
  input  logic [dacramp_pkg::FUNC_W-1:0] func_i,
  input  logic                           coil_on_i,
  input  logic [dacramp_pkg::LOAD_W-1:0] load_value_i,
  output dacramp_pkg::cmd_t              cmd_o
);
  import dacramp_pkg::*;

  always_comb begin
    cmd_o.value = load_value_i;
    case (func_i)
      FUNC_RAMP_TICK: cmd_o.op = OP_RAMP;
      FUNC_SLOW_TICK: cmd_o.op = OP_SLOW;
      FUNC_START:     cmd_o.op = coil_on_i ? OP_START   : OP_NONE;
      FUNC_STOP:      cmd_o.op = coil_on_i ? OP_STOP    : OP_NONE;
      FUNC_JOG1_UP:   cmd_o.op = coil_on_i ? OP_JOG1_UP : OP_NONE;
      FUNC_JOG1_DN:   cmd_o.op = coil_on_i ? OP_JOG1_DN : OP_NONE;
      FUNC_JOG2_UP:   cmd_o.op = coil_on_i ? OP_JOG2_UP : OP_NONE;
      FUNC_JOG2_DN:   cmd_o.op = coil_on_i ? OP_JOG2_DN : OP_NONE;
      FUNC_LOAD1:     cmd_o.op = OP_LOAD1;
      FUNC_LOAD2:     cmd_o.op = OP_LOAD2;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/dacramp_queue.sv -----
// Two-entry command queue between the decoder and the executor.
// Depends on dacramp_pkg for the command type and the queue sizing.
module dacramp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dacramp_pkg::cmd_t push_cmd_i,
  input  logic              pop_i,
  output dacramp_pkg::cmd_t head_cmd_o,
  output logic              full_o,
  output logic              empty_o
);
  import dacramp_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_no_pop_empty, !(pop_i && empty_o), "queue popped while empty")
  `ASSERT_CLK(a_no_push_full, !(push_i && full_o && !pop_i), "queue overrun")
  `ASSERT_NEXT(a_count_track, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
               "queue count did not advance on push")

endmodule

// ----- rtl/dacramp_back.sv -----
// Back end: executes queued commands on the ramp state and holds the result.
// Depends on dacramp_pkg; holds the configuration registers it uses.
module dacramp_back #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dacramp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dacramp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              cmd_avail_i,
  input  dacramp_pkg::cmd_t                 cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dacramp_pkg::OUT_W-1:0]     dac_one_o,
  output logic [dacramp_pkg::OUT_W-1:0]     dac_two_o,
  output logic                              dac_update_o,
  output logic                              relay_on_o,
  output logic                              auto_active_o
);
  import dacramp_pkg::*;

  localparam int unsigned DRV_W = DAC_BITS + 1;

  logic [STEP_W-1:0]   ramp_step_q;
  logic [JOG_W-1:0]    jog_max_q;
  logic [JOG_W-1:0]    jog_min_q;
  logic [DELAY_W-1:0]  off_delay_q;

  logic [DRV_W-1:0]    drive1_q, drive1_d, drive2_q, drive2_d;
  logic [DAC_BITS-1:0] target1_q, target1_d, target2_q, target2_d;
  logic                start_q, start_d, stop_q, stop_d;
  logic                auto_q, auto_d, relay_q, relay_d;
  logic [DELAY_W-1:0]  delay_q, delay_d;
  logic                update_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_one_q, out_two_q;
  logic                out_update_q, out_relay_q, out_auto_q;

  function automatic logic [DRV_W-1:0] ramp_ch(logic [DRV_W-1:0] drive,
                                               logic [DAC_BITS-1:0] target,
                                               logic [STEP_W-1:0] step);
    logic [DRV_W-1:0] tgt;
    tgt = DRV_W'(target);
    return (drive < tgt) ? drive + DRV_W'(step) : tgt;
  endfunction

  function automatic logic [DAC_BITS-1:0] jog(logic [DAC_BITS-1:0] target, logic up,
                                              logic [JOG_W-1:0] hi, logic [JOG_W-1:0] lo);
    logic [DAC_BITS-1:0] res;
    if (up) begin
      res = (32'(target) < 32'(hi)) ? target + 1'b1 : DAC_BITS'(hi);
    end else begin
      res = (32'(target) > 32'(lo)) ? target - 1'b1 : DAC_BITS'(lo);
    end
    return res;
  endfunction

  // Take the head command when the result slot is free or being drained.
  assign pop_o       = cmd_avail_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_comb begin
    drive1_d  = drive1_q;
    drive2_d  = drive2_q;
    target1_d = target1_q;
    target2_d = target2_q;
    start_d   = start_q;
    stop_d    = stop_q;
    auto_d    = auto_q;
    relay_d   = relay_q;
    delay_d   = delay_q;
    update_d  = 1'b0;
    case (cmd_i.op)
      OP_RAMP: begin
        if (start_q) begin
          start_d  = 1'b0;
          drive1_d = '0;
          drive2_d = '0;
          relay_d  = 1'b0;
          auto_d   = 1'b1;
        end
        if (auto_d && !stop_q) begin
          drive1_d = ramp_ch(drive1_d, target1_q, ramp_step_q);
          drive2_d = ramp_ch(drive2_d, target2_q, ramp_step_q);
          update_d = 1'b1;
        end else if (stop_q) begin
          drive1_d = '0;
          drive2_d = '0;
          auto_d   = 1'b0;
          stop_d   = 1'b0;
          delay_d  = off_delay_q;
          update_d = 1'b1;
        end
        if (drive1_d == DRV_W'(target1_q) && drive2_d == DRV_W'(target2_q)) begin
          auto_d = 1'b0;
        end
      end
      OP_SLOW: begin
        if (delay_q != '0) begin
          delay_d = delay_q - 1'b1;
          if (delay_q == DELAY_W'(1)) begin
            relay_d = 1'b1;
          end
        end
      end
      OP_START:   start_d   = 1'b1;
      OP_STOP:    stop_d    = 1'b1;
      OP_JOG1_UP: target1_d = jog(target1_q, 1'b1, jog_max_q, jog_min_q);
      OP_JOG1_DN: target1_d = jog(target1_q, 1'b0, jog_max_q, jog_min_q);
      OP_JOG2_UP: target2_d = jog(target2_q, 1'b1, jog_max_q, jog_min_q);
      OP_JOG2_DN: target2_d = jog(target2_q, 1'b0, jog_max_q, jog_min_q);
      OP_LOAD1:   target1_d = DAC_BITS'(cmd_i.value);
      OP_LOAD2:   target2_d = DAC_BITS'(cmd_i.value);
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q <= RAMP_STEP_RST;
      jog_max_q   <= JOG_MAX_RST;
      jog_min_q   <= JOG_MIN_RST;
      off_delay_q <= OFF_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RAMP_STEP: ramp_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_JOG_MAX:   jog_max_q   <= cfg_data_i[JOG_W-1:0];
        CFG_JOG_MIN:   jog_min_q   <= cfg_data_i[JOG_W-1:0];
        CFG_OFF_DELAY: off_delay_q <= cfg_data_i[DELAY_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive1_q    <= '0;
      drive2_q    <= '0;
      target1_q   <= '0;
      target2_q   <= '0;
      start_q     <= 1'b0;
      stop_q      <= 1'b0;
      auto_q      <= 1'b0;
      relay_q     <= 1'b0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        drive1_q  <= drive1_d;
        drive2_q  <= drive2_d;
        target1_q <= target1_d;
        target2_q <= target2_d;
        start_q   <= start_d;
        stop_q    <= stop_d;
        auto_q    <= auto_d;
        relay_q   <= relay_d;
        delay_q   <= delay_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_one_q    <= OUT_W'(drive1_d);
      out_two_q    <= OUT_W'(drive2_d);
      out_update_q <= update_d;
      out_relay_q  <= relay_d;
      out_auto_q   <= auto_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dac_one_o     = out_one_q;
  assign dac_two_o     = out_two_q;
  assign dac_update_o  = out_update_q;
  assign relay_on_o    = out_relay_q;
  assign auto_active_o = out_auto_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_relay_on_at_zero, !$rose(relay_q) || $past(delay_q) == DELAY_W'(1),
              "relay turned on without the off-delay expiring")
  `ASSERT_NEXT(a_stop_ends_auto, pop_o && cmd_i.op == OP_RAMP && stop_q,
               !auto_q && !stop_q && drive1_q == '0 && drive2_q == '0,
               "pending stop not applied on ramp tick")

endmodule

// ----- test/dacramp_checker.sv -----
// Scoreboard for the two-channel DAC soft-start ramp: mirrors register writes,
// predicts the result of every accepted event and compares the result channel.
// Depends on dacramp_pkg for function codes, register indexes and widths.
module dacramp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dacramp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dacramp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [dacramp_pkg::FUNC_W-1:0]    func_i,
  input  logic                              coil_on_i,
  input  logic [dacramp_pkg::LOAD_W-1:0]    load_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [dacramp_pkg::OUT_W-1:0]     dac_one_i,
  input  logic [dacramp_pkg::OUT_W-1:0]     dac_two_i,
  input  logic                              dac_update_i,
  input  logic                              relay_on_i,
  input  logic                              auto_active_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       compared_o,
  output int unsigned                       updates_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dacramp_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] dac_one;
    logic [OUT_W-1:0] dac_two;
    logic             update;
    logic             relay;
    logic             auto_on;
  } dac_result_t;

  dac_result_t dac_outputs_q[$];

  // Register copies.
  logic [STEP_W-1:0]  step_size;
  logic [JOG_W-1:0]   jog_hi;
  logic [JOG_W-1:0]   jog_lo;
  logic [DELAY_W-1:0] off_ticks;

  // Controller state.
  logic [OUT_W-1:0]   level_a, level_b;
  logic [JOG_W-1:0]   setpt_a, setpt_b;
  logic               start_req, stop_req, ramping, relay_en;
  logic [DELAY_W-1:0] off_count;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    compared_o   = 0;
    updates_o    = 0;
  end

  // Rise by one step while below the setpoint, else snap to it.
  function automatic logic [OUT_W-1:0] slew(input logic [OUT_W-1:0] lvl,
                                            input logic [JOG_W-1:0] setpt);
    if (lvl < setpt) return lvl + step_size;
    return setpt;
  endfunction

  function automatic logic [JOG_W-1:0] jog_setpoint(input logic [JOG_W-1:0] sp,
                                                    input logic up);
    if (up) return (sp < jog_hi) ? sp + 1'b1 : jog_hi;
    return (sp > jog_lo) ? sp - 1'b1 : jog_lo;
  endfunction

  function automatic dac_result_t apply_event(input logic [FUNC_W-1:0] f,
                                              input logic coil,
                                              input logic [LOAD_W-1:0] val);
    dac_result_t r;
    logic        upd;
    upd = 1'b0;
    case (f)
      FUNC_RAMP_TICK: begin
        if (start_req) begin
          start_req = 1'b0;
          level_a   = '0;
          level_b   = '0;
          relay_en  = 1'b0;
          ramping   = 1'b1;
        end
        if (ramping && !stop_req) begin
          level_a = slew(level_a, setpt_a);
          level_b = slew(level_b, setpt_b);
          upd     = 1'b1;
        end else if (stop_req) begin
          // a stop wins over a start taken on the same tick
          level_a   = '0;
          level_b   = '0;
          ramping   = 1'b0;
          stop_req  = 1'b0;
          off_count = off_ticks;
          upd       = 1'b1;
        end
        if (level_a == setpt_a && level_b == setpt_b) ramping = 1'b0;
      end
      FUNC_SLOW_TICK: begin
        if (off_count != 0) begin
          off_count = off_count - 1'b1;
          if (off_count == 0) relay_en = 1'b1;
        end
      end
      FUNC_START:   if (coil) start_req = 1'b1;
      FUNC_STOP:    if (coil) stop_req = 1'b1;
      FUNC_JOG1_UP: if (coil) setpt_a = jog_setpoint(setpt_a, 1'b1);
      FUNC_JOG1_DN: if (coil) setpt_a = jog_setpoint(setpt_a, 1'b0);
      FUNC_JOG2_UP: if (coil) setpt_b = jog_setpoint(setpt_b, 1'b1);
      FUNC_JOG2_DN: if (coil) setpt_b = jog_setpoint(setpt_b, 1'b0);
      FUNC_LOAD1:   setpt_a = val;
      FUNC_LOAD2:   setpt_b = val;
      default: ;
    endcase
    r.dac_one = level_a;
    r.dac_two = level_b;
    r.update  = upd;
    r.relay   = relay_en;
    r.auto_on = ramping;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count_o < 30)
      $display("%0t ns: result %0d %s: got %0d, want %0d",
               $time, compared_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    dac_result_t want;
    if (!rst_ni) begin
      step_size = RAMP_STEP_RST;
      jog_hi    = JOG_MAX_RST;
      jog_lo    = JOG_MIN_RST;
      off_ticks = OFF_DELAY_RST;
      level_a   = '0;
      level_b   = '0;
      setpt_a   = '0;
      setpt_b   = '0;
      start_req = 1'b0;
      stop_req  = 1'b0;
      ramping   = 1'b0;
      relay_en  = 1'b0;
      off_count = '0;
      dac_outputs_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAMP_STEP: step_size = cfg_data_i[STEP_W-1:0];
          CFG_JOG_MAX:   jog_hi    = cfg_data_i[JOG_W-1:0];
          CFG_JOG_MIN:   jog_lo    = cfg_data_i[JOG_W-1:0];
          CFG_OFF_DELAY: off_ticks = cfg_data_i[DELAY_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing: an item never comes back on its own edge
      if (out_valid_i && !out_stall_i) begin
        if (dac_outputs_q.size() == 0) begin
          report_mismatch("arrived with nothing outstanding", 1, 0);
        end else begin
          want = dac_outputs_q.pop_front();
          if (dac_one_i !== want.dac_one)
            report_mismatch("dac_one", dac_one_i, want.dac_one);
          if (dac_two_i !== want.dac_two)
            report_mismatch("dac_two", dac_two_i, want.dac_two);
          if (dac_update_i !== want.update)
            report_mismatch("dac_update", dac_update_i, want.update);
          if (relay_on_i !== want.relay)
            report_mismatch("relay_on", relay_on_i, want.relay);
          if (auto_active_i !== want.auto_on)
            report_mismatch("auto_active", auto_active_i, want.auto_on);
          if (want.update) updates_o++;
        end
        compared_o++;
      end
      if (in_valid_i && !in_stall_i)
        dac_outputs_q.push_back(apply_event(func_i, coil_on_i, load_value_i));
      pending_o = dac_outputs_q.size();
    end
  end

endmodule

// ----- test/two_channel_dac_soft_start_ramp_tb.sv -----
// Testbench top for the two-channel DAC soft-start ramp: drives events and
// register writes, stalls the result side, and reports the verdict.
// Depends on dacramp_pkg, the block under test and dacramp_checker.
module two_channel_dac_soft_start_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dacramp_pkg::*;

  // Function codes the block treats as no-ops.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 4'd10;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 4'd15;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic                 coil_on;
  logic [LOAD_W-1:0]    load_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     dac_one, dac_two;
  logic                 dac_update, relay_on, auto_active;

  int unsigned fail_count, pending, compared, updates;

  int unsigned        burst_left;
  int unsigned        events_sent;
  int unsigned        settings_run;
  logic [STEP_W-1:0]  cur_step;
  logic [DELAY_W-1:0] cur_off;
  bit                 hold_req;

  always #2 clk = ~clk;

  two_channel_dac_soft_start_ramp u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .coil_on_i    (coil_on),
    .load_value_i (load_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .dac_one_o    (dac_one),
    .dac_two_o    (dac_two),
    .dac_update_o (dac_update),
    .relay_on_o   (relay_on),
    .auto_active_o(auto_active)
  );

  dacramp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .coil_on_i    (coil_on),
    .load_value_i (load_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .dac_one_i    (dac_one),
    .dac_two_i    (dac_two),
    .dac_update_i (dac_update),
    .relay_on_i   (relay_on),
    .auto_active_i(auto_active),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared),
    .updates_o    (updates)
  );

  // Ignored items: spare codes, and coil-gated codes with the coil off.
  function automatic bit is_effective(input logic [FUNC_W-1:0] f, input logic coil);
    if (f > FUNC_LOAD2) return 1'b0;
    if (!coil && f >= FUNC_START && f <= FUNC_JOG2_DN) return 1'b0;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input logic [FUNC_W-1:0] f, input logic coil,
                            input logic [LOAD_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    func       <= f;
    coil_on    <= coil;
    load_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (is_effective(f, coil)) events_sent++;
  endtask

  // Drop in_valid and wait until every result is back.
  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] step_d, input logic [CFG_W-1:0] hi,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] off_d);
    write_reg(CFG_RAMP_STEP, step_d);
    write_reg(CFG_JOG_MAX, hi);
    write_reg(CFG_JOG_MIN, lo);
    write_reg(CFG_OFF_DELAY, off_d);
    cur_step = step_d[STEP_W-1:0];
    cur_off  = off_d[DELAY_W-1:0];
    settings_run++;
  endtask

  // Mostly setpoints reachable in a few dozen ticks, sometimes anything.
  function automatic logic [LOAD_W-1:0] pick_target();
    logic [LOAD_W-1:0] t;
    int unsigned       span;
    span = ((cur_step == 0) ? 1 : cur_step) * 40;
    if (span > 4095) span = 4095;
    case ($urandom_range(0, 7))
      0:       t = $urandom_range(0, 4095);
      1:       t = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
      default: t = $urandom_range(0, span);
    endcase
    return t;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_jog();
    case ($urandom_range(0, 3))
      0:       return FUNC_JOG1_UP;
      1:       return FUNC_JOG1_DN;
      2:       return FUNC_JOG2_UP;
      default: return FUNC_JOG2_DN;
    endcase
  endfunction

  // Load setpoints, start, and tick toward them; the tick count is capped and a stop may cut in.
  task automatic ramp_run();
    logic [LOAD_W-1:0] t1, t2;
    int unsigned       steps, stop_at;
    t1 = pick_target();
    t2 = pick_target();
    send_event(FUNC_LOAD1, $urandom_range(0, 1), t1);
    send_event(FUNC_LOAD2, $urandom_range(0, 1), t2);
    send_event(FUNC_START, 1'b1, $urandom);
    steps = (cur_step == 0) ? 8 : ((t1 > t2) ? t1 : t2) / cur_step + 3;
    if (steps > 90) steps = 90;
    stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, steps) : steps + 1;
    for (int i = 0; i < steps; i++) begin
      if (i == stop_at) send_event(FUNC_STOP, 1'b1, $urandom);
      case ($urandom_range(0, 11))
        0:       send_event(pick_jog(), $urandom_range(0, 1), $urandom);
        1:       send_event(FUNC_SLOW_TICK, $urandom_range(0, 1), $urandom);
        default: ;
      endcase
      send_event(FUNC_RAMP_TICK, $urandom_range(0, 1), $urandom);
    end
  endtask

  // Stop, then count the off delay down, usually far enough to close the relay.
  task automatic stop_and_decay();
    int unsigned n;
    if ($urandom_range(0, 3) == 0) send_event(FUNC_START, 1'b1, $urandom);
    send_event(FUNC_STOP, 1'b1, $urandom);
    send_event(FUNC_RAMP_TICK, $urandom_range(0, 1), $urandom);
    n = cur_off + 2;
    if (n > 40 && $urandom_range(0, 3) != 0) n = 40;
    repeat (n) send_event(FUNC_SLOW_TICK, $urandom_range(0, 1), $urandom);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_event($urandom_range(0, 15), $urandom_range(0, 1), $urandom);
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned goal;
    goal = events_sent + n;
    while (events_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: ramp_run();
        6, 7:             stop_and_decay();
        default:          noise_burst();
      endcase
    end
    drain();
  endtask

  // Result side: stall patterns, plus long hold-offs that back up the input.
  initial begin : receiver
    int unsigned mode, len, hold;
    bit          held;
    out_stall = 1'b0;
    held      = 1'b0;
    @(posedge rst_n);
    forever begin
      if ((hold_req && !held) || $urandom_range(0, 24) == 0) begin
        held = 1'b1;
        hold = $urandom_range(40, 90);
        repeat (hold) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 80);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] d_step, d_off;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_RAMP_STEP;
    cfg_data     = '0;
    in_valid     = 1'b0;
    func         = FUNC_RAMP_TICK;
    coil_on      = 1'b0;
    load_value   = '0;
    burst_left   = 0;
    events_sent  = 0;
    settings_run = 1;
    cur_step     = RAMP_STEP_RST;
    cur_off      = OFF_DELAY_RST;
    hold_req     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass at the reset register values.
    send_event(FUNC_LOAD1, 1'b0, 12'hFFF);
    send_event(FUNC_LOAD2, 1'b1, 12'h000);
    send_event(FUNC_SPARE_LO, 1'b1, 12'hAAA);
    send_event(FUNC_SPARE_HI, 1'b0, 12'h555);
    send_event(FUNC_START, 1'b0, 12'h000);
    send_event(FUNC_RAMP_TICK, 1'b0, 12'h000);
    send_event(FUNC_START, 1'b1, 12'hFFF);
    send_event(FUNC_RAMP_TICK, 1'b1, 12'hFFF);
    send_event(FUNC_JOG1_UP, 1'b1, 12'h000);
    send_event(FUNC_JOG1_DN, 1'b1, 12'h000);
    send_event(FUNC_JOG2_DN, 1'b1, 12'h000);
    send_event(FUNC_JOG2_UP, 1'b0, 12'h000);
    send_event(FUNC_JOG2_UP, 1'b1, 12'h000);
    send_event(FUNC_STOP, 1'b0, 12'h000);
    send_event(FUNC_RAMP_TICK, 1'b0, 12'h000);
    // start and stop pending together on one tick
    send_event(FUNC_STOP, 1'b1, 12'h000);
    send_event(FUNC_START, 1'b1, 12'h000);
    send_event(FUNC_RAMP_TICK, 1'b1, 12'h000);
    repeat (3) send_event(FUNC_SLOW_TICK, 1'b1, 12'h000);
    // stop while not ramping
    send_event(FUNC_STOP, 1'b1, 12'h000);
    send_event(FUNC_RAMP_TICK, 1'b0, 12'h000);
    send_event(FUNC_LOAD2, 1'b0, 12'h555);
    send_event(FUNC_LOAD1, 1'b1, 12'hAAA);
    drain();

    // Smallest step, full jog range, one-tick off delay.
    apply_setting(12'h001, 12'hFFF, 12'h000, 12'hF01);
    hold_req = 1'b1;
    run_phase(320);

    // Largest step, inverted jog limits, zero off delay.
    apply_setting(12'hAFF, 12'h000, 12'hFFF, 12'h300);
    run_phase(320);

    // Zero step (upper data bits set), longest off delay.
    apply_setting(12'h100, 12'd2000, 12'd1000, 12'h0FF);
    run_phase(150);

    d_step = $urandom;
    if (d_step[STEP_W-1:0] == 0) d_step[0] = 1'b1;
    d_off = $urandom;
    d_off[7:6] = 2'b00;
    apply_setting(d_step, $urandom, $urandom, d_off);
    run_phase(320);

    apply_setting(12'd37, 12'hFFF, 12'd100, 12'd5);
    run_phase(320);

    d_step = $urandom;
    if (d_step[STEP_W-1:0] == 0) d_step[0] = 1'b1;
    d_off = $urandom;
    d_off[7:6] = 2'b00;
    apply_setting(d_step, $urandom, $urandom, d_off);
    run_phase(300);

    $display("Sent %0d events under %0d register settings; %0d results checked,",
             events_sent, settings_run, compared);
    $display("%0d of them DAC updates, with stalls backing up the input queue.", updates);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
